// File: hdl/mtt_pkg.sv
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int LEN_W = 6;
    localparam int PAT_BYTES = 28;
    localparam int PAT_BITS = 8 * PAT_BYTES;
    localparam int STR_BYTES = 16;
    localparam int STR_BITS = 8 * STR_BYTES;
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    // Strongs number starts at this tag offset; copy stops before NUM_END
    localparam logic [LEN_W-1:0] NUM_START = 6'd27;
    localparam logic [LEN_W:0]   NUM_END   = 7'd48;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_P  = 8'h50;

    localparam logic [LEN_W-1:0] LEN_SYNC        = 6'd28;
    localparam logic [LEN_W-1:0] LEN_NOTE_OPEN   = 6'd17;
    localparam logic [LEN_W-1:0] LEN_NOTE_CLOSE  = 6'd5;
    localparam logic [LEN_W-1:0] LEN_FOREIGN     = 6'd17;
    localparam logic [LEN_W-1:0] LEN_FOREIGN_END = 6'd8;
    localparam logic [LEN_W-1:0] LEN_BR          = 6'd2;

    localparam logic [PAT_BITS-1:0] PAT_SYNC_G = "sync type=\"Strongs\" value=\"G";
    localparam logic [PAT_BITS-1:0] PAT_SYNC_H = "sync type=\"Strongs\" value=\"H";
    localparam logic [PAT_BITS-1:0] PAT_NOTE_OPEN =
        {"note place=\"foot\"", {(PAT_BYTES - 17) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_NOTE_CLOSE =
        {"/note", {(PAT_BYTES - 5) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_GREEK =
        {"foreign lang=\"el\"", {(PAT_BYTES - 17) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_HEBREW =
        {"foreign lang=\"he\"", {(PAT_BYTES - 17) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_FOREIGN_END =
        {"/foreign", {(PAT_BYTES - 8) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_BR_LO = {"br", {(PAT_BYTES - 2) * 8{1'b0}}};
    localparam logic [PAT_BITS-1:0] PAT_BR_UP = {"BR", {(PAT_BYTES - 2) * 8{1'b0}}};

    localparam logic [STR_BITS-1:0] STR_SYNC   = {"<W", {14 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_RF     = {"<RF>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_RF_END = {"<Rf>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_GREEK  = {"<FNSIL Galatia>", 8'h00};
    localparam logic [STR_BITS-1:0] STR_HEBREW = {"<FNSIL Ezra>", {4 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_FN     = {"<Fn>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_CL     = {"<CL>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_FI     = {"<FI>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_FB     = {"<FB>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_CM     = {"<CM>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_FI_END = {"<Fi>", {12 * 8{1'b0}}};
    localparam logic [STR_BITS-1:0] STR_FB_END = {"<Fb>", {12 * 8{1'b0}}};

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        K_PASS          = 4'd0,
        K_SYNC          = 4'd1,
        K_NOTE_OPEN     = 4'd2,
        K_NOTE_CLOSE    = 4'd3,
        K_GREEK         = 4'd4,
        K_HEBREW        = 4'd5,
        K_FOREIGN_CLOSE = 4'd6,
        K_LINE          = 4'd7,
        K_ITAL_OPEN     = 4'd8,
        K_BOLD_OPEN     = 4'd9,
        K_PARA_CLOSE    = 4'd10,
        K_ITAL_CLOSE    = 4'd11,
        K_BOLD_CLOSE    = 4'd12
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] rd_addr;
        logic             sync_done;
    } back_req_t;

    typedef struct packed {
        logic sync_g;
        logic sync_h;
        logic note_open;
        logic note_close;
        logic greek;
        logic hebrew;
        logic foreign_end;
        logic br_lo;
        logic br_up;
    } match_t;

    // true while the byte at position p does not contradict the pattern
    function automatic logic pat_hit(
        input logic [PAT_BITS-1:0] pat,
        input logic [LEN_W-1:0]    n,
        input logic [LEN_W-1:0]    p,
        input logic [7:0]          b
    );
        logic hit;
        if (p >= n)
        begin
            hit = 1'b1;
        end
        else
        begin
            hit = (b == pat[8 * (PAT_BYTES - 1 - int'(p)) +: 8]);
        end
        return hit;
    endfunction

    function automatic logic [7:0] str_byte(
        input cmd_kind_t  kind,
        input logic [3:0] k
    );
        logic [STR_BITS-1:0] s;
        case (kind)
            K_SYNC:          s = STR_SYNC;
            K_NOTE_OPEN:     s = STR_RF;
            K_NOTE_CLOSE:    s = STR_RF_END;
            K_GREEK:         s = STR_GREEK;
            K_HEBREW:        s = STR_HEBREW;
            K_FOREIGN_CLOSE: s = STR_FN;
            K_LINE:          s = STR_CL;
            K_ITAL_OPEN:     s = STR_FI;
            K_BOLD_OPEN:     s = STR_FB;
            K_PARA_CLOSE:    s = STR_CM;
            K_ITAL_CLOSE:    s = STR_FI_END;
            K_BOLD_CLOSE:    s = STR_FB_END;
            default:         s = '0;
        endcase
        return s[8 * (STR_BYTES - 1 - int'(k)) +: 8];
    endfunction

    function automatic logic [3:0] str_last(input cmd_kind_t kind);
        logic [3:0] n;
        case (kind)
            K_PASS:   n = 4'd0;
            K_SYNC:   n = 4'd1;
            K_GREEK:  n = 4'd14;
            K_HEBREW: n = 4'd11;
            default:  n = 4'd3;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/mtt_fifo.sv
`timescale 1ns / 1ps

module mtt_fifo #(
    parameter type data_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  data_t wdata,
    output logic  full,
    input  logic  pop,
    output data_t rdata,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    data_t           slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/mtt_front.sv
`timescale 1ns / 1ps

module mtt_front #(
    parameter int TAG_CAPACITY = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mtt_pkg::in_item_t    in_data,
    output logic                 full,
    output logic                 cmd_push,
    output mtt_pkg::cmd_t        cmd_data,
    input  logic                 cmd_full,
    input  mtt_pkg::back_req_t   back_req,
    output logic [7:0]           rd_data
);

    localparam int AW = $clog2(TAG_CAPACITY);

    logic [7:0]                 tag_mem [TAG_CAPACITY];
    logic [7:0]                 rd_data_reg;
    logic                       inside_reg;
    logic                       inside_next;
    logic [mtt_pkg::LEN_W-1:0]  len_reg;
    logic [mtt_pkg::LEN_W-1:0]  len_next;
    logic [7:0]                 c0_reg;
    logic [7:0]                 c1_reg;
    mtt_pkg::match_t            match_reg;
    mtt_pkg::match_t            match_next;
    logic                       sync_busy_reg;
    logic                       sync_busy_next;
    logic                       accept;
    logic                       store;
    logic [7:0]                 b;
    logic                       has1;
    logic                       has2;
    logic                       c0_i;
    logic                       c0_b;
    logic                       c0_slash;
    logic                       c1_p;
    logic                       c1_i;
    logic                       c1_b;

    assign full    = cmd_full || sync_busy_reg;
    assign accept  = push && !full;
    assign b       = in_data.in_byte;
    assign rd_data = rd_data_reg;

    assign store = accept && !in_data.end_of_text && (b != mtt_pkg::CH_LT)
                   && (b != mtt_pkg::CH_GT) && inside_reg
                   && (len_reg < mtt_pkg::LEN_W'(TAG_CAPACITY));

    assign has1     = (len_reg >= 6'd1);
    assign has2     = (len_reg >= 6'd2);
    assign c0_i     = has1 && ((c0_reg == mtt_pkg::CH_LO_I) || (c0_reg == mtt_pkg::CH_UP_I));
    assign c0_b     = has1 && ((c0_reg == mtt_pkg::CH_LO_B) || (c0_reg == mtt_pkg::CH_UP_B));
    assign c0_slash = has1 && (c0_reg == mtt_pkg::CH_SLASH);
    assign c1_p     = has2 && ((c1_reg == mtt_pkg::CH_LO_P) || (c1_reg == mtt_pkg::CH_UP_P));
    assign c1_i     = has2 && ((c1_reg == mtt_pkg::CH_LO_I) || (c1_reg == mtt_pkg::CH_UP_I));
    assign c1_b     = has2 && ((c1_reg == mtt_pkg::CH_LO_B) || (c1_reg == mtt_pkg::CH_UP_B));

    always_comb
    begin
        inside_next    = inside_reg;
        len_next       = len_reg;
        match_next     = match_reg;
        sync_busy_next = sync_busy_reg;
        cmd_push       = 1'b0;
        cmd_data.kind  = mtt_pkg::K_PASS;
        cmd_data.data  = b;
        cmd_data.len   = len_reg;

        if (back_req.sync_done)
        begin
            sync_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (in_data.end_of_text)
            begin
                cmd_push      = 1'b1;
                cmd_data.data = 8'h00;
                len_next      = '0;
                inside_next   = 1'b0;
            end
            else if (b == mtt_pkg::CH_LT)
            begin
                inside_next = 1'b1;
                len_next    = '0;
                match_next  = '1;
            end
            else if (b == mtt_pkg::CH_GT)
            begin
                if (inside_reg)
                begin
                    inside_next = 1'b0;
                    cmd_push    = 1'b1;
                    if ((match_reg.sync_g || match_reg.sync_h)
                        && (len_reg >= mtt_pkg::LEN_SYNC))
                    begin
                        cmd_data.kind  = mtt_pkg::K_SYNC;
                        sync_busy_next = 1'b1;
                    end
                    else if (match_reg.note_open && (len_reg >= mtt_pkg::LEN_NOTE_OPEN))
                    begin
                        cmd_data.kind = mtt_pkg::K_NOTE_OPEN;
                    end
                    else if (match_reg.note_close && (len_reg >= mtt_pkg::LEN_NOTE_CLOSE))
                    begin
                        cmd_data.kind = mtt_pkg::K_NOTE_CLOSE;
                    end
                    else if (match_reg.greek && (len_reg >= mtt_pkg::LEN_FOREIGN))
                    begin
                        cmd_data.kind = mtt_pkg::K_GREEK;
                    end
                    else if (match_reg.hebrew && (len_reg >= mtt_pkg::LEN_FOREIGN))
                    begin
                        cmd_data.kind = mtt_pkg::K_HEBREW;
                    end
                    else if (match_reg.foreign_end
                             && (len_reg >= mtt_pkg::LEN_FOREIGN_END))
                    begin
                        cmd_data.kind = mtt_pkg::K_FOREIGN_CLOSE;
                    end
                    else if ((match_reg.br_lo || match_reg.br_up)
                             && (len_reg >= mtt_pkg::LEN_BR))
                    begin
                        cmd_data.kind = mtt_pkg::K_LINE;
                    end
                    else if (c0_i)
                    begin
                        cmd_data.kind = mtt_pkg::K_ITAL_OPEN;
                    end
                    else if (c0_b)
                    begin
                        cmd_data.kind = mtt_pkg::K_BOLD_OPEN;
                    end
                    else if (c0_slash && c1_p)
                    begin
                        cmd_data.kind = mtt_pkg::K_PARA_CLOSE;
                    end
                    else if (c0_slash && c1_i)
                    begin
                        cmd_data.kind = mtt_pkg::K_ITAL_CLOSE;
                    end
                    else if (c0_slash && c1_b)
                    begin
                        cmd_data.kind = mtt_pkg::K_BOLD_CLOSE;
                    end
                    else
                    begin
                        cmd_push = 1'b0;
                    end
                end
            end
            else if (inside_reg)
            begin
                if (store)
                begin
                    len_next = len_reg + 6'd1;
                    match_next.sync_g = match_reg.sync_g
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_SYNC_G, mtt_pkg::LEN_SYNC, len_reg, b);
                    match_next.sync_h = match_reg.sync_h
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_SYNC_H, mtt_pkg::LEN_SYNC, len_reg, b);
                    match_next.note_open = match_reg.note_open
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_NOTE_OPEN, mtt_pkg::LEN_NOTE_OPEN,
                                            len_reg, b);
                    match_next.note_close = match_reg.note_close
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_NOTE_CLOSE, mtt_pkg::LEN_NOTE_CLOSE,
                                            len_reg, b);
                    match_next.greek = match_reg.greek
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_GREEK, mtt_pkg::LEN_FOREIGN,
                                            len_reg, b);
                    match_next.hebrew = match_reg.hebrew
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_HEBREW, mtt_pkg::LEN_FOREIGN,
                                            len_reg, b);
                    match_next.foreign_end = match_reg.foreign_end
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_FOREIGN_END,
                                            mtt_pkg::LEN_FOREIGN_END, len_reg, b);
                    match_next.br_lo = match_reg.br_lo
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_BR_LO, mtt_pkg::LEN_BR, len_reg, b);
                    match_next.br_up = match_reg.br_up
                        && mtt_pkg::pat_hit(mtt_pkg::PAT_BR_UP, mtt_pkg::LEN_BR, len_reg, b);
                end
            end
            else
            begin
                cmd_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            len_reg       <= '0;
            match_reg     <= '1;
            sync_busy_reg <= 1'b0;
        end
        else
        begin
            inside_reg    <= inside_next;
            len_reg       <= len_next;
            match_reg     <= match_next;
            sync_busy_reg <= sync_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            tag_mem[len_reg[AW-1:0]] <= b;
            if (len_reg == 6'd0)
            begin
                c0_reg <= b;
            end
            if (len_reg == 6'd1)
            begin
                c1_reg <= b;
            end
        end
        rd_data_reg <= tag_mem[back_req.rd_addr[AW-1:0]];
    end

endmodule

// File: hdl/mtt_back.sv
`timescale 1ns / 1ps

module mtt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mtt_pkg::cmd_t       cmd_rdata,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output mtt_pkg::back_req_t  back_req,
    input  logic [7:0]          rd_data,
    output logic                out_push,
    output mtt_pkg::out_item_t  out_item,
    input  logic                out_full
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EMIT   = 5'b00010,
        ST_NUM_RD = 5'b00100,
        ST_NUM    = 5'b01000,
        ST_CLOSE  = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    mtt_pkg::cmd_t              cmd_reg;
    mtt_pkg::cmd_t              cmd_next;
    logic [3:0]                 k_reg;
    logic [3:0]                 k_next;
    logic [mtt_pkg::LEN_W-1:0]  idx_reg;
    logic [mtt_pkg::LEN_W-1:0]  idx_next;
    logic [mtt_pkg::LEN_W:0]    idx_inc;
    logic                       str_done;

    assign idx_inc  = {1'b0, idx_reg} + 7'd1;
    assign str_done = (cmd_reg.kind == mtt_pkg::K_PASS)
                      || (k_reg == mtt_pkg::str_last(cmd_reg.kind));

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        k_next             = k_reg;
        idx_next           = idx_reg;
        cmd_pop            = 1'b0;
        out_push           = 1'b0;
        out_item.out_byte  = 8'h00;
        out_item.last_of_run = 1'b0;
        back_req.rd_addr   = idx_reg;
        back_req.sync_done = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_rdata;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    out_item.out_byte = (cmd_reg.kind == mtt_pkg::K_PASS)
                                        ? cmd_reg.data
                                        : mtt_pkg::str_byte(cmd_reg.kind, k_reg);
                    if (!str_done)
                    begin
                        k_next = k_reg + 4'd1;
                    end
                    else if (cmd_reg.kind == mtt_pkg::K_SYNC)
                    begin
                        idx_next   = mtt_pkg::NUM_START;
                        state_next = (mtt_pkg::NUM_START < cmd_reg.len) ? ST_NUM_RD : ST_CLOSE;
                    end
                    else
                    begin
                        out_item.last_of_run = 1'b1;
                        k_next = '0;
                        if (!cmd_empty)
                        begin
                            cmd_pop  = 1'b1;
                            cmd_next = cmd_rdata;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_NUM_RD:
            begin
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                if (rd_data == mtt_pkg::CH_QUOTE)
                begin
                    state_next = ST_CLOSE;
                end
                else if (!out_full)
                begin
                    out_push          = 1'b1;
                    out_item.out_byte = rd_data;
                    idx_next          = idx_inc[mtt_pkg::LEN_W-1:0];
                    if ((idx_inc < {1'b0, cmd_reg.len}) && (idx_inc < mtt_pkg::NUM_END))
                    begin
                        state_next = ST_NUM_RD;
                    end
                    else
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (!out_full)
                begin
                    out_push             = 1'b1;
                    out_item.out_byte    = mtt_pkg::CH_GT;
                    out_item.last_of_run = 1'b1;
                    back_req.sync_done   = 1'b1;
                    k_next               = '0;
                    if (!cmd_empty)
                    begin
                        cmd_pop    = 1'b1;
                        cmd_next   = cmd_rdata;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        k_reg   <= k_next;
        idx_reg <= idx_next;
    end

endmodule

// File: hdl/markup_tag_translator_unit.sv
`timescale 1ns / 1ps
// Throughput: one input per cycle for text and tag bytes while full is low; the result side
// moves one byte per cycle for replacement tags while the result queue has room, and each
// Strongs digit waits for a registered tag-memory read before it is queued.
// Input stays full from a Strongs tag's '>' until its '>' result is queued.
// Reset: asynchronous, active low; clears tag length, tag state and all queues.
// The tag memory is not cleared; only written entries are ever read.

module markup_tag_translator_unit #(
    parameter int TAG_CAPACITY = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mtt_pkg::in_item_t   in_data,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output mtt_pkg::out_item_t  out_data
);

    mtt_pkg::cmd_t       cmd_wdata;
    mtt_pkg::cmd_t       cmd_rdata;
    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_pop;
    logic                cmd_empty;
    mtt_pkg::back_req_t  back_req;
    logic [7:0]          rd_data;
    logic                out_push;
    logic                out_full;
    mtt_pkg::out_item_t  out_item;

    mtt_front #(
        .TAG_CAPACITY (TAG_CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_wdata),
        .cmd_full (cmd_full),
        .back_req (back_req),
        .rd_data  (rd_data)
    );

    mtt_fifo #(
        .data_t (mtt_pkg::cmd_t),
        .DEPTH  (mtt_pkg::CMDQ_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    mtt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_rdata (cmd_rdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .back_req  (back_req),
        .rd_data   (rd_data),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    mtt_fifo #(
        .data_t (mtt_pkg::out_item_t),
        .DEPTH  (mtt_pkg::OUTQ_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_data),
        .empty (empty)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TAG_CAP = 48;
    localparam int MAX_OUT = 24;
    localparam int RANDOM_ITEMS = 50;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS = 60;

    typedef struct {
        string      text;
        logic [7:0] raw;
        bit         eot;
        bit         typed;
        string      want;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    mtt_pkg::in_item_t  in_data = '0;
    logic               full;
    logic               empty;
    logic               pop = 1'b0;
    mtt_pkg::out_item_t out_data;

    // translator state as seen by the prediction
    logic [7:0] tag_mem [0:63];
    logic [5:0] tag_len = '0;
    bit         in_tag = 1'b0;

    mtt_pkg::out_item_t step_text[$];
    mtt_pkg::out_item_t expected_text[$];
    logic [7:0]         tok[$];
    script_row_t        script[$];

    string sync_head = "sync type=\"Strongs\" value=\"";
    string tag_names[$] = '{"note place=\"foot\"", "/note", "foreign lang=\"el\"",
                            "foreign lang=\"he\"", "/foreign", "br", "BR", "i", "I",
                            "b", "B", "/p", "/P", "/i", "/I", "/b", "/B"};

    int mismatches = 0;
    int items_sent = 0;
    int cycles = 0;
    int pop_wait = 0;
    int popped = 0;

    markup_tag_translator_unit #(
        .TAG_CAPACITY(TAG_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .in_data(in_data),
        .full(full),
        .empty(empty),
        .pop(pop),
        .out_data(out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** markup_tag_translator_unit: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == mtt_pkg::CH_LT || b == mtt_pkg::CH_GT)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void add_str(input string s);
        for (int k = 0; k < s.len(); k++)
            tok.push_back(s[k]);
    endfunction

    function automatic void emit(input logic [7:0] b);
        mtt_pkg::out_item_t o;
        o.out_byte = b;
        o.last_of_run = 1'b0;
        if (step_text.size() < MAX_OUT)
            step_text.push_back(o);
    endfunction

    function automatic void emit_str(input string s);
        for (int k = 0; k < s.len(); k++)
            emit(s[k]);
    endfunction

    function automatic bit tag_has(input string p);
        if (tag_len < p.len())
            return 1'b0;
        for (int k = 0; k < p.len(); k++)
            if (tag_mem[k] != p[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void decode_tag();
        logic [7:0] c0;
        logic [7:0] c1;
        int         k;
        c0 = (tag_len > 0) ? tag_mem[0] : 8'h00;
        c1 = (tag_len > 1) ? tag_mem[1] : 8'h00;
        if (tag_has(sync_head) && tag_len > sync_head.len()
            && (tag_mem[sync_head.len()] == "G" || tag_mem[sync_head.len()] == "H"))
        begin
            emit_str("<W");
            k = sync_head.len();
            while (k < tag_len && step_text.size() < MAX_OUT - 1
                   && tag_mem[k] != mtt_pkg::CH_QUOTE)
            begin
                emit(tag_mem[k]);
                k++;
            end
            emit(mtt_pkg::CH_GT);
        end
        else if (tag_has("note place=\"foot\""))
            emit_str("<RF>");
        else if (tag_has("/note"))
            emit_str("<Rf>");
        else if (tag_has("foreign lang=\"el\""))
            emit_str("<FNSIL Galatia>");
        else if (tag_has("foreign lang=\"he\""))
            emit_str("<FNSIL Ezra>");
        else if (tag_has("/foreign"))
            emit_str("<Fn>");
        else if (tag_has("br") || tag_has("BR"))
            emit_str("<CL>");
        else if (c0 == mtt_pkg::CH_LO_I || c0 == mtt_pkg::CH_UP_I)
            emit_str("<FI>");
        else if (c0 == mtt_pkg::CH_LO_B || c0 == mtt_pkg::CH_UP_B)
            emit_str("<FB>");
        else if (c0 == mtt_pkg::CH_SLASH)
        begin
            if (c1 == mtt_pkg::CH_LO_P || c1 == mtt_pkg::CH_UP_P)
                emit_str("<CM>");
            else if (c1 == mtt_pkg::CH_LO_I || c1 == mtt_pkg::CH_UP_I)
                emit_str("<Fi>");
            else if (c1 == mtt_pkg::CH_LO_B || c1 == mtt_pkg::CH_UP_B)
                emit_str("<Fb>");
        end
    endfunction

    // bytes produced by one input transaction, left in step_text
    function automatic void translate_step(input mtt_pkg::in_item_t it);
        mtt_pkg::out_item_t o;
        step_text.delete();
        if (it.end_of_text)
        begin
            emit(8'h00);
            tag_len = '0;
            in_tag = 1'b0;
        end
        else if (it.in_byte == mtt_pkg::CH_LT)
        begin
            in_tag = 1'b1;
            tag_len = '0;
        end
        else if (it.in_byte == mtt_pkg::CH_GT)
        begin
            if (in_tag)
            begin
                in_tag = 1'b0;
                decode_tag();
            end
        end
        else if (in_tag)
        begin
            if (tag_len < TAG_CAP)
            begin
                tag_mem[tag_len] = it.in_byte;
                tag_len = tag_len + 1'b1;
            end
        end
        else
        begin
            emit(it.in_byte);
        end
        if (step_text.size() > 0)
        begin
            o = step_text.pop_back();
            o.last_of_run = 1'b1;
            step_text.push_back(o);
        end
    endfunction

    task automatic send_item(input mtt_pkg::in_item_t it, input bit typed_row);
        int gap;
        push <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        translate_step(it);
        if (!typed_row)
            foreach (step_text[k])
                expected_text.push_back(step_text[k]);
        items_sent++;
        gap = pick_gap(((items_sent / 40) % 3) == 1);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: check each popped transaction, stall pop at random
    always @(posedge clk)
    begin
        mtt_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            popped++;
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_data.out_byte != want.out_byte)
                    report_mismatch($sformatf("byte %0d out_byte %02h, expected %02h",
                                              popped, out_data.out_byte, want.out_byte));
                if (out_data.last_of_run != want.last_of_run)
                    report_mismatch($sformatf("byte %0d last_of_run %0b, expected %0b",
                                              popped, out_data.last_of_run,
                                              want.last_of_run));
            end
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_wait > 0)
        begin
            pop <= 1'b0;
            pop_wait <= pop_wait - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_wait <= pick_gap(((cycles / 500) % 4) == 2);
        end
    end

    initial
    begin
        mtt_pkg::in_item_t  it;
        mtt_pkg::out_item_t o;
        int                 first_random;
        int                 pick;
        int                 n;
        string              word;
        bit                 tok_eot;

        script.push_back('{"", 8'h00, 1'b0, 1'b0, ""});
        script.push_back('{"", 8'hFF, 1'b0, 1'b0, ""});
        script.push_back('{"A", 8'h00, 1'b0, 1'b1, "A"});
        script.push_back('{">", 8'h00, 1'b0, 1'b1, ""});
        script.push_back('{"<br>", 8'h00, 1'b0, 1'b1, "<CL>"});
        script.push_back('{"<BR/>", 8'h00, 1'b0, 1'b1, "<CL>"});
        script.push_back('{"<i>", 8'h00, 1'b0, 1'b1, "<FI>"});
        script.push_back('{"<B class=x>", 8'h00, 1'b0, 1'b1, "<FB>"});
        script.push_back('{"</p>", 8'h00, 1'b0, 1'b1, "<CM>"});
        script.push_back('{"</I>", 8'h00, 1'b0, 1'b1, "<Fi>"});
        script.push_back('{"</b>", 8'h00, 1'b0, 1'b1, "<Fb>"});
        script.push_back('{"<note place=\"foot\">", 8'h00, 1'b0, 1'b1, "<RF>"});
        script.push_back('{"</note>", 8'h00, 1'b0, 1'b1, "<Rf>"});
        script.push_back('{"<foreign lang=\"el\">", 8'h00, 1'b0, 1'b1, "<FNSIL Galatia>"});
        script.push_back('{"<foreign lang=\"he\">", 8'h00, 1'b0, 1'b1, "<FNSIL Ezra>"});
        script.push_back('{"</foreign>", 8'h00, 1'b0, 1'b1, "<Fn>"});
        script.push_back('{{"<", sync_head, "G3056\" />"}, 8'h00, 1'b0, 1'b1, "<WG3056>"});
        script.push_back('{{"<", sync_head, "H\">"}, 8'h00, 1'b0, 1'b1, "<WH>"});
        script.push_back('{{"<", sync_head, "H123456789012345678901234567890>"},
                          8'h00, 1'b0, 1'b0, ""});
        script.push_back('{{"<", sync_head, "X12\">"}, 8'h00, 1'b0, 1'b1, ""});
        script.push_back('{"<>", 8'h00, 1'b0, 1'b1, ""});
        script.push_back('{"<p<br>", 8'h00, 1'b0, 1'b1, "<CL>"});
        script.push_back('{"<br", 8'h00, 1'b0, 1'b1, ""});
        script.push_back('{"", mtt_pkg::CH_LT, 1'b1, 1'b1, ""});
        script.push_back('{">", 8'h00, 1'b0, 1'b1, ""});
        script.push_back('{"", 8'hFF, 1'b1, 1'b1, ""});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r])
        begin
            if (script[r].typed)
            begin
                if (script[r].eot)
                begin
                    o.out_byte = 8'h00;
                    o.last_of_run = 1'b1;
                    expected_text.push_back(o);
                end
                else
                begin
                    for (int k = 0; k < script[r].want.len(); k++)
                    begin
                        o.out_byte = script[r].want[k];
                        o.last_of_run = (k == script[r].want.len() - 1);
                        expected_text.push_back(o);
                    end
                end
            end
            it.end_of_text = script[r].eot;
            if (script[r].text.len() == 0)
            begin
                it.in_byte = script[r].raw;
                send_item(it, script[r].typed);
            end
            else
            begin
                for (int k = 0; k < script[r].text.len(); k++)
                begin
                    it.in_byte = script[r].text[k];
                    send_item(it, script[r].typed);
                end
            end
        end

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            tok.delete();
            tok_eot = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                add_str({"<", sync_head});
                tok.push_back($urandom_range(0, 1) ? "G" : "H");
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
                repeat (n) tok.push_back(8'h30 + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 4) != 0)
                    add_str("\" /");
                tok.push_back(mtt_pkg::CH_GT);
            end
            else if (pick < 55)
            begin
                add_str({"<", tag_names[$urandom_range(0, tag_names.size() - 1)]});
                repeat ($urandom_range(0, 4)) tok.push_back(rand_text_byte());
                tok.push_back(mtt_pkg::CH_GT);
            end
            else if (pick < 65)
            begin
                tok.push_back(mtt_pkg::CH_LT);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 8);
                repeat (n) tok.push_back(rand_text_byte());
                tok.push_back(mtt_pkg::CH_GT);
            end
            else if (pick < 73)
            begin
                // near miss: one byte of a known tag replaced with a random text byte
                if ($urandom_range(0, 1))
                    word = {sync_head, "G12"};
                else
                    word = tag_names[$urandom_range(0, tag_names.size() - 1)];
                word.putc($urandom_range(0, word.len() - 1), rand_text_byte());
                add_str({"<", word, ">"});
            end
            else if (pick < 80)
            begin
                // unclosed tag prefix, either restarted by a nested '<' or left open
                word = tag_names[$urandom_range(0, tag_names.size() - 1)];
                add_str({"<", word.substr(0, $urandom_range(0, word.len() - 1))});
                if ($urandom_range(0, 1))
                    add_str({"<", tag_names[$urandom_range(0, tag_names.size() - 1)], ">"});
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6)) tok.push_back(rand_text_byte());
            end
            else if (pick < 96)
            begin
                tok.push_back(mtt_pkg::CH_GT);
            end
            else
            begin
                tok_eot = 1'b1;
            end

            if (tok_eot)
            begin
                it.in_byte = 8'($urandom_range(0, 255));
                it.end_of_text = 1'b1;
                send_item(it, 1'b0);
            end
            else
            begin
                foreach (tok[k])
                begin
                    it.in_byte = tok[k];
                    it.end_of_text = 1'b0;
                    send_item(it, 1'b0);
                end
            end
        end

        push <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!empty)
            report_mismatch("result left over after the last expected byte");

        if (mismatches == 0)
            $display("** markup_tag_translator_unit: PASSED **");
        else
            $display("** markup_tag_translator_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hdl/mtt_pkg.sv
hdl/mtt_fifo.sv
hdl/mtt_front.sv
hdl/mtt_back.sv
hdl/markup_tag_translator_unit.sv
test/tb.sv
